/* rtl/itoa_pkg.sv */
package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] MINUS_CHAR  = 7'h2d;
  localparam logic [CHAR_W-1:0] ZERO_CHAR   = 7'h30;
  localparam logic [CHAR_W-1:0] LETTER_BASE = 7'h61;

  // controller -> datapath
  typedef struct packed {
    logic load;        // take a new value, clear counters
    logic step;        // one restoring division step
    logic push;        // store remainder as next digit
    logic rd;          // read top of digit stack
    logic emit_sign;   // load '-' into output register
    logic emit_digit;  // load stack top into output register, pop
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic step_last;   // final step of the current division
    logic quo_zero;    // quotient of the finished division is zero
    logic neg;         // value being converted is negative
    logic one_left;    // exactly one digit remains on the stack
    logic out_free;    // output register can take a character
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < 6'd10) begin
      digit_char = ZERO_CHAR + d_ext;
    end else begin
      digit_char = LETTER_BASE + d_ext - 7'd10;
    end
  endfunction

endpackage

/* rtl/itoa_ifs.sv */
interface itoa_in_if #(parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itoa_out_if;
  logic                          valid;
  logic                          ready;
  logic [itoa_pkg::CHAR_W-1:0]   character;
  logic                          last;
  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface itoa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [itoa_pkg::RADIX_W-1:0]  radix;
  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

/* rtl/integer_to_radix_ascii.sv */
// Signed integer to ASCII text in a programmable radix.
// in_ch  : one signed VALUE_WIDTH-bit value per transfer; ready only while idle.
// out_ch : one ASCII character per transfer, most significant first, '-' leading
//          for negative values, lower-case letters above nine; last marks the
//          final character of a value. Zero gives a single '0'.
// cfg_ch : 6-bit radix, always ready; 0 and 1 act as 2, 37..63 act as 36.
//          Write it only while idle; the radix is sampled when a value arrives.
// Timing : each digit comes from the bit-serial divider (one quotient bit a
//          cycle), and its remainder is then stacked; each character is later
//          popped from the digit stack RAM and loaded into the output register.
// Reset  : rst_n (synchronous) returns to idle, drops out valid and sets radix 10.
// Stall  : a held output register holds the character; conversion of the
//          current value pauses until it is taken.
module integer_to_radix_ascii #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  itoa_in_if.sink     in_ch,
  itoa_out_if.source  out_ch,
  itoa_cfg_if.sink    cfg_ch
);

  itoa_pkg::cmd_t cmd;
  itoa_pkg::sts_t sts;
  logic           cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_ch.value),
    .cfg_valid     (cfg_wr),
    .cfg_radix     (cfg_ch.radix),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_character (out_ch.character),
    .out_last      (out_ch.last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

/* rtl/itoa_ram.sv */
module itoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/itoa_ctrl.sv */
module itoa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  itoa_pkg::sts_t sts,
  output itoa_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_PUSH = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_LOAD = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.step_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        if (!sts.quo_zero) begin
          state_nxt = ST_DIV;
        end else if (sts.neg) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // hold the read data until the output register frees up
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          state_nxt      = sts.one_left ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.push, cmd.rd, cmd.emit_sign, cmd.emit_digit}))
    else $error("more than one datapath command at once");

  a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_DIV))
    else $error("division did not start after transfer in");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && sts.one_left) |=> in_ready)
    else $error("not idle after final character");

endmodule

/* rtl/itoa_dp.sv */
module itoa_dp #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [VALUE_WIDTH-1:0]        in_value,
  input  logic                          cfg_valid,
  input  logic [itoa_pkg::RADIX_W-1:0]  cfg_radix,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [itoa_pkg::CHAR_W-1:0]   out_character,
  output logic                          out_last,
  input  itoa_pkg::cmd_t                cmd,
  output itoa_pkg::sts_t                sts
);

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam int SW = $clog2(VALUE_WIDTH);
  localparam int RW = itoa_pkg::RADIX_W;

  logic [RW-1:0]                 radix_r, radix_nxt;
  logic [RW-1:0]                 radix_eff_r, radix_eff_nxt;
  logic [VALUE_WIDTH-1:0]        mag_r, mag_nxt;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;
  logic [SW-1:0]                 step_r, step_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [itoa_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [RW:0]                   trial;
  logic [RW:0]                   trial_sub;
  logic                          trial_ge;
  logic [RW-1:0]                 radix_clamp;
  logic [CW-1:0]                 rd_idx;
  logic [RW-1:0]                 rd_data;
  logic                          step_last;
  logic                          out_free;

  assign step_last = (step_r == SW'(VALUE_WIDTH - 1));
  assign out_free  = !out_valid_r || out_ready;
  assign rd_idx    = cnt_r - CW'(1);

  always_comb begin
    if (radix_r < itoa_pkg::RADIX_MIN) begin
      radix_clamp = itoa_pkg::RADIX_MIN;
    end else if (radix_r > itoa_pkg::RADIX_MAX) begin
      radix_clamp = itoa_pkg::RADIX_MAX;
    end else begin
      radix_clamp = radix_r;
    end
  end

  // restoring division: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem_r, mag_r[VALUE_WIDTH-1]};
  assign trial_sub = trial - {1'b0, radix_eff_r};
  assign trial_ge  = (trial >= {1'b0, radix_eff_r});

  always_comb begin
    radix_nxt     = cfg_valid ? cfg_radix : radix_r;
    radix_eff_nxt = radix_eff_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (cmd.load) begin
      radix_eff_nxt = radix_clamp;
      neg_nxt       = in_value[VALUE_WIDTH-1];
      mag_nxt       = in_value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - in_value) : in_value;
      rem_nxt       = '0;
      step_nxt      = '0;
      cnt_nxt       = '0;
    end
    if (cmd.step) begin
      rem_nxt  = trial_ge ? trial_sub[RW-1:0] : trial[RW-1:0];
      mag_nxt  = {mag_r[VALUE_WIDTH-2:0], trial_ge};
      step_nxt = step_last ? '0 : step_r + SW'(1);
    end
    if (cmd.push) begin
      cnt_nxt  = cnt_r + CW'(1);
      rem_nxt  = '0;
      step_nxt = '0;
    end
    if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = itoa_pkg::MINUS_CHAR;
      out_last_nxt  = 1'b0;
    end
    if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = itoa_pkg::digit_char(rd_data);
      out_last_nxt  = (cnt_r == CW'(1));
      cnt_nxt       = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= itoa_pkg::RADIX_RESET;
      radix_eff_r <= itoa_pkg::RADIX_RESET;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      radix_r     <= radix_nxt;
      radix_eff_r <= radix_eff_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // digit stack, least significant digit at the bottom
  itoa_ram #(
    .WIDTH (RW),
    .DEPTH (VALUE_WIDTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (cnt_r[AW-1:0]),
    .wdata (rem_r),
    .re    (cmd.rd),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_data)
  );

  assign sts.step_last = step_last;
  assign sts.quo_zero  = (mag_r == '0);
  assign sts.neg       = neg_r;
  assign sts.one_left  = (cnt_r == CW'(1));
  assign sts.out_free  = out_free;

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (cnt_r < CW'(VALUE_WIDTH)))
    else $error("digit stack overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.emit_digit) |-> (cnt_r != '0))
    else $error("digit stack read while empty");

  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (radix_eff_r >= itoa_pkg::RADIX_MIN) && (radix_eff_r <= itoa_pkg::RADIX_MAX))
    else $error("working radix out of range");

endmodule

/* dv/tb_integer_to_radix_ascii.sv */
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii;

  localparam int VALUE_W        = itoa_pkg::VALUE_WIDTH_DEF;
  localparam int RW             = itoa_pkg::RADIX_W;
  localparam int CW             = itoa_pkg::CHAR_W;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int TAIL_CYCLES    = 60;
  localparam int PHASE_ITEMS    = 38;

  typedef struct packed {
    logic [CW-1:0] character;
    logic          last;
  } text_char_t;

  logic clk;
  logic rst_n;

  itoa_in_if  #(.VALUE_WIDTH(VALUE_W)) in_ch ();
  itoa_out_if                          out_ch ();
  itoa_cfg_if                          cfg_ch ();

  integer_to_radix_ascii #(.VALUE_WIDTH(VALUE_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  text_char_t    text_due[$];
  logic [RW-1:0] radix_now;
  int            mismatches;
  int            quiet_cycles;
  int            stall_left;
  bit            steady;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int base_of(input logic [RW-1:0] setting);
    if (setting < itoa_pkg::RADIX_MIN) return int'(itoa_pkg::RADIX_MIN);
    if (setting > itoa_pkg::RADIX_MAX) return int'(itoa_pkg::RADIX_MAX);
    return int'(setting);
  endfunction

  // Text of one value, most significant character first
  function automatic void predict_text(input logic [VALUE_W-1:0] v,
                                       input logic [RW-1:0] setting);
    string              digit_set;
    logic [VALUE_W-1:0] mag;
    int                 base;
    int                 digits[$];
    text_char_t         c;
    digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
    base      = base_of(setting);
    mag       = v[VALUE_W-1] ? -v : v;
    do begin
      digits.push_front(int'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (v[VALUE_W-1]) begin
      c.character = itoa_pkg::MINUS_CHAR;
      c.last      = 1'b0;
      text_due.push_back(c);
    end
    foreach (digits[k]) begin
      c.character = CW'(digit_set[digits[k]]);
      c.last      = (k == digits.size() - 1);
      text_due.push_back(c);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: %s", $time, what);
  endtask

  // Hold valid across back-to-back items; drop it only for a gap
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    predict_text(v, radix_now);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (text_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RW-1:0] r);
    cfg_ch.valid <= 1'b1;
    cfg_ch.radix <= r;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    radix_now = r;
  endtask

  function automatic logic [VALUE_W-1:0] random_value(input int base);
    longint p;
    longint lim;
    int     n;
    logic [VALUE_W-1:0] v;
    lim = longint'(1) << (VALUE_W - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: v = VALUE_W'($urandom);
      3:       v = VALUE_W'($urandom_range(0, 200) - 100);
      4: begin
        p = 1;
        n = $urandom_range(1, VALUE_W);
        repeat (n) if (p * base < lim) p = p * base;
        p = p + $urandom_range(0, 2) - 1;
        v = VALUE_W'($urandom_range(0, 1) ? -p : p);
      end
      5: begin
        case ($urandom_range(0, 4))
          0: v = {1'b0, {(VALUE_W-1){1'b1}}};
          1: v = {1'b1, {(VALUE_W-1){1'b0}}};
          2: v = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
          3: v = '0;
          default: v = '1;
        endcase
      end
      default: begin
        v = VALUE_W'($urandom >> $urandom_range(0, VALUE_W - 1));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Receiver: random stalls after transfers and now and then while waiting
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ((out_ch.valid && out_ch.ready) || $urandom_range(0, 15) == 0) begin
      n = pick_gap();
      out_ch.ready <= (n == 0);
      if (n > 0) stall_left <= n - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    text_char_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (text_due.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h (last %b) with no value pending",
                                  out_ch.character, out_ch.last));
      end else begin
        due = text_due.pop_front();
        if (out_ch.character !== due.character)
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                    out_ch.character, due.character));
        if (out_ch.last !== due.last)
          report_mismatch($sformatf("last %b on character 0x%02h, expected %b",
                                    out_ch.last, due.character, due.last));
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("integer_to_radix_ascii regression: fail");
        $finish;
      end
    end
  end

  task automatic test_reset_radix();
    send_value('0);
    send_value(1);
    send_value('1);
    send_value({1'b0, {(VALUE_W-1){1'b1}}});
    send_value({1'b1, {(VALUE_W-1){1'b0}}});
    send_value(9);
    send_value(10);
    send_value(-10);
    wait_drained();
  endtask

  // Radix extremes, and settings outside two to thirty-six that clamp
  task automatic test_radix_limits();
    write_radix(itoa_pkg::RADIX_MIN);
    send_value({1'b0, {(VALUE_W-1){1'b1}}});
    send_value({1'b1, {(VALUE_W-1){1'b0}}});
    wait_drained();
    write_radix(itoa_pkg::RADIX_MAX);
    send_value({1'b1, {(VALUE_W-1){1'b0}}});
    send_value(35);
    wait_drained();
    write_radix(6'd0);
    send_value(5);
    wait_drained();
    write_radix(6'd1);
    send_value(-6);
    wait_drained();
    write_radix(6'd37);
    send_value(35);
    wait_drained();
    write_radix(6'd63);
    send_value({1'b1, {(VALUE_W-2){1'b0}}, 1'b1});
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [RW-1:0] plan[9];
    plan[0] = itoa_pkg::RADIX_MIN;
    plan[1] = itoa_pkg::RADIX_MAX;
    plan[2] = 6'd16;
    plan[3] = RW'($urandom_range(itoa_pkg::RADIX_MIN, itoa_pkg::RADIX_MAX));
    plan[4] = RW'($urandom_range(itoa_pkg::RADIX_MIN, itoa_pkg::RADIX_MAX));
    plan[5] = RW'($urandom_range(0, 1));
    plan[6] = RW'($urandom_range(itoa_pkg::RADIX_MAX + 1, 63));
    plan[7] = RW'($urandom_range(3, 9));
    plan[8] = 6'd10;
    foreach (plan[ph]) begin
      steady = (ph == 2 || ph == 7);
      write_radix(plan[ph]);
      repeat (PHASE_ITEMS) begin
        send_value(random_value(base_of(radix_now)));
        // hold off now and then until the text is all out
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.radix = '0;
    radix_now    = itoa_pkg::RADIX_RESET;
    mismatches   = 0;
    steady       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_radix();
    test_radix_limits();
    test_random_phases();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("integer_to_radix_ascii regression: pass");
    end else begin
      $display("integer_to_radix_ascii regression: fail");
    end
    $finish;
  end

endmodule
